### rtl/sync_length_xor_frame_receiver_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLXFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slxfr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLXFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slxfr check failed");

`endif

### rtl/slxfr_pkg.sv
`default_nettype none

package slxfr_pkg;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SYNC_FIRST  = 1'b0,
		REG_SYNC_SECOND = 1'b1
	} slxfr_reg_t;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	// Deframer phases.
	typedef enum logic [1:0] {
		ST_HUNT   = 2'd0,
		ST_SYNC2  = 2'd1,
		ST_LENGTH = 2'd2,
		ST_BODY   = 2'd3
	} slxfr_state_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       frame_end;
		logic       frame_good;
	} slxfr_result_t;

endpackage

`default_nettype wire

### rtl/slxfr_if.sv
`default_nettype none

interface slxfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slxfr_res_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       frame_end;
	logic       frame_good;

	modport source (output valid, output data_valid, output data_byte,
		output frame_end, output frame_good, input ready);
	modport sink (input valid, input data_valid, input data_byte,
		input frame_end, input frame_good, output ready);
endinterface

`default_nettype wire

### rtl/sync_length_xor_frame_receiver_core.sv
// A byte accepted from the input is registered in stage one; its result is then registered
// in stage two, which drives the result port and holds it until it is taken.
// Throughput: one byte per cycle while the result side keeps up; each byte updates the frame state
// (phase, remaining length and running XOR) once. A stalled result holds stage two.
// Reset (arst_n low, asynchronous): hunting for the first sync byte, both
// pipeline stages empty, sync registers back to 0xAA and 0x55.
`default_nettype none

module sync_length_xor_frame_receiver_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	slxfr_rx_if.sink        rx,
	slxfr_res_if.source     res,
	input  wire logic       cfg_write,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	// Stage one holds the received byte; stage two holds the finished result.
	// Each stage moves on whenever the stage after it is empty or being
	// emptied, so a new transaction is taken every cycle while the result
	// side keeps up. A stalled result holds stage two, and stage one as well
	// once it is full, at which point the input is stalled.

	logic [7:0] sync_first;
	logic [7:0] sync_second;

	logic       vld_s1;
	logic [7:0] rx_byte_s1;
	logic       vld_s2;
	slxfr_pkg::slxfr_result_t res_s2;
	slxfr_pkg::slxfr_result_t result;

	logic adv_s2;
	logic step;

	slxfr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sync_first (sync_first),
		.sync_second(sync_second)
	);

	// Stage two can take a new result when it is empty or its result leaves now.
	assign adv_s2   = !vld_s2 || res.ready;
	// The frame state advances exactly once per byte, when it moves into stage two.
	assign step     = vld_s1 && adv_s2;
	assign rx.ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	slxfr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (rx_byte_s1),
		.sync_first (sync_first),
		.sync_second(sync_second),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	// Every received byte yields exactly one result transaction; bytes outside
	// a frame give a result with all flags low and a zero data byte.
	assign res.valid      = vld_s2;
	assign res.data_valid = res_s2.data_valid;
	assign res.data_byte  = res_s2.data_byte;
	assign res.frame_end  = res_s2.frame_end;
	assign res.frame_good = res_s2.frame_good;

endmodule

`default_nettype wire

### rtl/slxfr_cfg.sv
`default_nettype none

module slxfr_cfg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output logic [7:0]      sync_first,
	output logic [7:0]      sync_second
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= slxfr_pkg::SYNC_FIRST_RST;
			sync_second_q <= slxfr_pkg::SYNC_SECOND_RST;
		end else if (cfg_write) begin
			unique case (slxfr_pkg::slxfr_reg_t'(cfg_index))
				slxfr_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				slxfr_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
			endcase
		end
	end

	assign sync_first  = sync_first_q;
	assign sync_second = sync_second_q;

endmodule

`default_nettype wire

### rtl/slxfr_parse.sv
`default_nettype none

module slxfr_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [7:0]        sync_first,
	input  wire logic [7:0]        sync_second,
	output slxfr_pkg::slxfr_result_t result
);

	slxfr_pkg::slxfr_state_t state_q, state_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] xor_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= slxfr_pkg::ST_HUNT;
			remain_q <= '0;
			xor_q    <= '0;
		end else if (step) begin
			state_q  <= state_d;
			remain_q <= remain_d;
			xor_q    <= xor_d;
		end
	end

	assign xor_next = xor_q ^ rx_byte;

	// remain_q counts the payload bytes still due; at zero the byte is the checksum.
	always_comb begin
		state_d  = state_q;
		remain_d = remain_q;
		xor_d    = xor_q;
		result   = '0;
		unique case (state_q)
			slxfr_pkg::ST_HUNT: begin
				if (rx_byte == sync_first) state_d = slxfr_pkg::ST_SYNC2;
			end
			slxfr_pkg::ST_SYNC2: begin
				state_d = (rx_byte == sync_second) ? slxfr_pkg::ST_LENGTH
				                                   : slxfr_pkg::ST_HUNT;
			end
			slxfr_pkg::ST_LENGTH: begin
				remain_d = rx_byte;
				xor_d    = rx_byte;
				state_d  = slxfr_pkg::ST_BODY;
			end
			slxfr_pkg::ST_BODY: begin
				xor_d = xor_next;
				if (remain_q == 8'd0) begin
					result.frame_end  = 1'b1;
					result.frame_good = (xor_next == 8'd0);
					state_d           = slxfr_pkg::ST_HUNT;
				end else begin
					result.data_valid = 1'b1;
					result.data_byte  = rx_byte;
					remain_d          = remain_q - 8'd1;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/slxfr_checker.sv
`default_nettype none
`include "sync_length_xor_frame_receiver_core_macros.svh"

module slxfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_data_valid,
	input wire logic [7:0] res_data_byte,
	input wire logic       res_frame_end,
	input wire logic       res_frame_good
);

	logic [10:0] res_payload;

	assign res_payload = {res_data_valid, res_data_byte, res_frame_end, res_frame_good};

	`SLXFR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload))
	`SLXFR_ASSERT_SAME(a_data_not_end, clk, arst_n, res_valid && res_data_valid, !res_frame_end)
	`SLXFR_ASSERT_SAME(a_good_needs_end, clk, arst_n, res_valid && res_frame_good, res_frame_end)
	`SLXFR_ASSERT_SAME(a_idle_byte_zero, clk, arst_n, res_valid && !res_data_valid, res_data_byte == 8'd0)

endmodule

bind sync_length_xor_frame_receiver_core slxfr_checker u_slxfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_data_valid(res.data_valid),
	.res_data_byte (res.data_byte),
	.res_frame_end (res.frame_end),
	.res_frame_good(res.frame_good)
);

`default_nettype wire
